>>> hdl/tape_pkg.sv
// Package for the threshold alert projection encoder.
// Holds the sequencer state types, thresholds, weight and tanh tables and
// the divider constants. It depends on nothing else.
package tape_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_RISE,
    ST_MULV,
    ST_SUM,
    ST_ABS,
    ST_SATCHK,
    ST_DIV,
    ST_TMUL,
    ST_TFIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_EST,
    DV_BACK,
    DV_FIX
  } div_state_t;

  typedef logic signed [19:0] coef_tab_t [32];

  localparam int NUM_ROWS = 5;
  localparam int NUM_COLS = 32;
  localparam int QUOT_W = 18;
  localparam int TANH_FRAC_BITS = 14;
  localparam int RECIP_SHIFT = 20;

  localparam longint DIV_DEN = 64'sd3000000;
  localparam longint DIV_HALF = 64'sd1500000;
  localparam longint DIV_RECIP = (64'sd1 <<< (2 * RECIP_SHIFT)) / DIV_DEN;
  localparam logic [50:0] SAT_LIM = 51'd786432000000;
  localparam logic signed [19:0] RISE_GAIN = 20'sd300;
  localparam logic signed [15:0] TANH_MAX = 16'sd32767;

  localparam logic signed [31:0] VAL_LIM [5] = '{
    32'sd32768000, 32'sd3276800, 32'sd32768000, 32'sd3276800, 32'sd6553
  };
  localparam logic signed [31:0] RISE_LIM [5] = '{
    32'sd13107200, 32'sd3276800, 32'sd6553600, 32'sd1310720, 32'sd655
  };

  localparam logic [15:0] TANH_TAB [17] = '{
    16'd0, 16'd8025, 16'd15143, 16'd20813, 16'd24956, 16'd27797, 16'd29660,
    16'd30847, 16'd31589, 16'd32048, 16'd32329, 16'd32501, 16'd32606,
    16'd32670, 16'd32708, 16'd32732, 16'd32746
  };

  localparam int ROW_FAC [NUM_ROWS] = '{10, 6, 15, 30, 3000};

  localparam int WT [NUM_ROWS * NUM_COLS] = '{
    85, 12, -44, 91, 33, -21, 77, 5, 62, -19, 41, 88, -31, 54, 11, -67,
    29, 83, -15, 47, 66, -38, 92, 14, 51, -27, 73, 9, -45, 61, 35, -81,
    34, 95, 18, -52, 71, 43, -16, 89, -37, 64, 22, -79, 58, 3, 86, 27,
    -61, 49, 76, -11, 38, 82, -24, 67, 15, 93, -48, 31, 70, -5, 56, 19,
    -22, 41, 87, 19, -63, 78, 31, -44, 85, 12, -56, 39, 74, -28, 65, 8,
    91, -33, 46, 80, -17, 53, 26, -71, 40, 68, 13, -84, 25, 59, -36, 72,
    67, -31, 52, 84, 9, -76, 48, 23, -90, 37, 61, -14, 45, 79, -26, 58,
    17, -69, 35, 81, -42, 28, 64, 6, -88, 43, 57, -21, 39, 75, -18, 50,
    19, 74, -29, 63, 88, 7, -55, 42, 71, -36, 80, 25, -68, 49, 16, 93,
    -21, 58, 34, -77, 62, 11, -49, 86, 30, -64, 53, 79, -13, 47, 28, -70
  };

  // Each column folds the weights over the scales onto the common
  // denominator of the divider.
  function automatic coef_tab_t build_coef();
    coef_tab_t t;
    int acc;
    for (int c = 0; c < NUM_COLS; c++) begin
      acc = 0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        acc = acc + ROW_FAC[r] * WT[r * NUM_COLS + c];
      end
      t[c] = 20'(acc);
    end
    return t;
  endfunction

  localparam coef_tab_t COEF_TAB = build_coef();

endpackage

>>> hdl/tape_div.sv
// Divider by the fixed argument denominator: a reciprocal multiply gives a
// quotient estimate that a remainder check raises by up to two; done is
// registered after DV_FIX. Uses tape_pkg for the constants and phase type.
module tape_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  output logic [17:0] quot,
  output logic        done
);
  import tape_pkg::*;

  localparam logic [21:0] Den = 22'(DIV_DEN);
  localparam logic [19:0] Recip = 20'(DIV_RECIP);
  localparam logic [39:0] DenTwice = 40'(2 * DIV_DEN);

  div_state_t phase;
  div_state_t phase_next;

  logic [39:0] num;
  logic [17:0] qest;
  logic [39:0] rem;
  logic [21:0] mul_x;
  logic [19:0] mul_y;
  logic [41:0] mul_p;

  assign mul_p = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DV_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    mul_x      = 22'(num[39:RECIP_SHIFT]);
    mul_y      = Recip;
    case (phase)
      DV_IDLE: begin
        if (start) begin
          phase_next = DV_EST;
        end
      end
      DV_EST: begin
        phase_next = DV_BACK;
      end
      DV_BACK: begin
        mul_x      = Den;
        mul_y      = 20'(qest);
        phase_next = DV_FIX;
      end
      DV_FIX: begin
        phase_next = DV_IDLE;
      end
      default: begin
        phase_next = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (phase == DV_FIX);
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      DV_IDLE: begin
        if (start) begin
          num <= dividend;
        end
      end
      DV_EST: begin
        qest <= mul_p[RECIP_SHIFT +: QUOT_W];
      end
      DV_BACK: begin
        rem <= num - mul_p[39:0];
      end
      DV_FIX: begin
        if (rem >= DenTwice) begin
          quot <= qest + 18'd2;
        end else if (rem >= 40'(Den)) begin
          quot <= qest + 18'd1;
        end else begin
          quot <= qest;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/threshold_alert_projection_encoder_top.sv
// Top level of the threshold alert projection encoder.
// Uses tape_pkg and instantiates tape_div.
//
// Usage:
// The input channel (in_valid, in_stall) takes one telemetry sample per
// transfer. The block keeps the last primary value of each stream and
// forms the saturated rise. A sample whose value or rise exceeds its
// stream's thresholds produces VECTOR_LENGTH output transfers, one per
// column, with last set on the final one; other samples produce none.
// A sample with a stream id of STREAM_COUNT or more is taken and ignored.
// Each column of an alerting sample runs through one shared multiplier
// and a reciprocal divider; the divider is skipped when tanh saturates.
// The input stalls for the whole sample. While out_stall is high the
// current column holds on the output ports and nothing advances. Reset
// clears the stored stream values to zero and returns the sequencer to
// idle.
module threshold_alert_projection_encoder_top #(
  parameter int STREAM_COUNT  = 5,
  parameter int VECTOR_LENGTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         stream_id,
  input  logic signed [31:0] sample_value,
  input  logic signed [31:0] second_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         alert_stream,
  output logic [4:0]         element_index,
  output logic signed [15:0] embedding_value,
  output logic signed [31:0] echo_value,
  output logic signed [31:0] echo_second,
  output logic signed [31:0] rise,
  output logic               last
);
  import tape_pkg::*;

  localparam int SidW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam logic [4:0] LastCol = 5'(VECTOR_LENGTH - 1);
  localparam logic [2:0] StreamLim = 3'(STREAM_COUNT);

  state_t state;
  state_t state_next;

  logic [2:0]         sid;
  logic signed [31:0] v;
  logic signed [31:0] v2;
  logic signed [31:0] d;
  logic signed [40:0] rise300;
  logic signed [51:0] prod;
  logic signed [52:0] s;
  logic               neg;
  logic [50:0]        mag;
  logic [4:0]         col;
  logic signed [15:0] emb;
  logic signed [31:0] prev [STREAM_COUNT];

  logic [SidW-1:0]    sid_idx;
  logic signed [31:0] prev_rd;
  logic [32:0]        diff33;
  logic signed [31:0] d_sat;
  logic               alert;

  logic signed [31:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [51:0] mul_p;

  logic               div_start;
  logic               div_done;
  logic [17:0]        quot;

  logic [4:0]         tidx;
  logic [13:0]        frac;
  logic [12:0]        tdiff;
  logic [15:0]        ymag;

  assign sid_idx = sid[SidW-1:0];
  assign prev_rd = prev[sid_idx];
  assign diff33  = {v[31], v} - {prev_rd[31], prev_rd};

  always_comb begin
    if (diff33[32] != diff33[31]) begin
      d_sat = diff33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      d_sat = signed'(diff33[31:0]);
    end
  end

  assign alert = (v > VAL_LIM[sid]) || (d > RISE_LIM[sid]);
  assign mul_p = mul_a * mul_b;

  assign tidx  = {1'b0, quot[17:14]};
  assign frac  = quot[13:0];
  assign tdiff = 13'(TANH_TAB[tidx + 5'd1] - TANH_TAB[tidx]);
  assign ymag  = TANH_TAB[tidx] + 16'((prod[27:0] + 28'd8192) >> TANH_FRAC_BITS);

  tape_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag[39:0]),
    .quot     (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    div_start  = 1'b0;
    mul_a      = v;
    mul_b      = COEF_TAB[col];
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (stream_id < StreamLim)) begin
          state_next = ST_DELTA;
        end
      end
      ST_DELTA: begin
        state_next = ST_RISE;
      end
      ST_RISE: begin
        mul_a      = d;
        mul_b      = RISE_GAIN;
        state_next = alert ? ST_MULV : ST_IDLE;
      end
      ST_MULV: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_ABS;
      end
      ST_ABS: begin
        state_next = ST_SATCHK;
      end
      ST_SATCHK: begin
        if (mag >= SAT_LIM) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_TMUL;
        end
      end
      ST_TMUL: begin
        mul_a      = signed'({19'b0, tdiff});
        mul_b      = signed'({6'b0, frac});
        state_next = ST_TFIN;
      end
      ST_TFIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = (col == LastCol) ? ST_IDLE : ST_MULV;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STREAM_COUNT; i++) begin
        prev[i] <= '0;
      end
    end else if (state == ST_DELTA) begin
      prev[sid_idx] <= v;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sid <= stream_id;
        v   <= sample_value;
        v2  <= second_value;
      end
      ST_DELTA: begin
        d <= d_sat;
      end
      ST_RISE: begin
        rise300 <= mul_p[40:0];
        col     <= '0;
      end
      ST_MULV: begin
        prod <= mul_p;
      end
      ST_SUM: begin
        s <= 53'(prod) + 53'(rise300);
      end
      ST_ABS: begin
        neg <= s[52];
        mag <= s[52] ? 51'(DIV_HALF - s) : 51'(s + DIV_HALF);
      end
      ST_SATCHK: begin
        emb <= neg ? -TANH_MAX : TANH_MAX;
      end
      ST_TMUL: begin
        prod <= mul_p;
      end
      ST_TFIN: begin
        emb <= neg ? -signed'(ymag) : signed'(ymag);
      end
      ST_OUT: begin
        if (!out_stall && (col != LastCol)) begin
          col <= col + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign alert_stream    = sid;
  assign element_index   = col;
  assign embedding_value = emb;
  assign echo_value      = v;
  assign echo_second     = v2;
  assign rise            = d;
  assign last            = (col == LastCol);

endmodule
